// File: rtl/window_sigma_outlier_filter_core_macros.svh
// assertion macros for the window sigma outlier filter core
// expects aclk and aresetn in the scope of the module that uses them
`ifndef WINDOW_SIGMA_OUTLIER_FILTER_CORE_MACROS_SVH
`define WINDOW_SIGMA_OUTLIER_FILTER_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define WSOF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define WSOF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wsof_pkg.sv
// shared types and constants of the window sigma outlier filter
// no dependencies
package wsof_pkg;

    localparam int STAMP_W    = 32;
    localparam int SAMPLE_W   = 16;
    localparam int KEPT_W     = 20;
    localparam logic [KEPT_W-1:0] KEPT_MAX = {KEPT_W{1'b1}};
    localparam int WINDOW_DEF = 5;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [STAMP_W-1:0]         stamp;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       final_sample;
    } wsof_in_t;

    typedef struct packed {
        logic [STAMP_W-1:0]         out_stamp;
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       run_last;
        logic                       stream_done;
        logic [KEPT_W-1:0]          kept_total;
    } wsof_out_t;

    // one kept sample on its way from the front to the back
    typedef struct packed {
        logic [STAMP_W-1:0]         stamp;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       run_last;
        logic                       stream_done;
    } wsof_emit_t;

endpackage

// File: rtl/wsof_front.sv
// front part: accepts samples, holds the window, decides the middle sample
// with one shared squaring multiplier and pushes kept samples; uses wsof_pkg
module wsof_front #(
    parameter int WINDOW = wsof_pkg::WINDOW_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  wsof_pkg::wsof_in_t    s_data,
    output logic                  push_valid,
    input  logic                  push_ready,
    output wsof_pkg::wsof_emit_t  push_data
);
    import wsof_pkg::*;

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int IDX_W = $clog2(WINDOW);
    localparam int MID   = WINDOW / 2;
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW) + 1;
    localparam int DW    = SUM_W + 1;
    localparam int PW    = 2 * DW;
    localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0] MID_CNT = CNT_W'(MID);
    localparam logic [CNT_W-1:0] MID_NXT = CNT_W'(MID + 1);
    localparam logic signed [DW-1:0] WIN_D = DW'(WINDOW);
    localparam logic signed [PW-1:0] WIN_P = PW'(WINDOW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OLD,
        ST_DIFF,
        ST_SQ,
        ST_CMP,
        ST_EMIT
    } state_t;

    state_t                     state_reg;
    logic signed [SAMPLE_W-1:0] win_val_reg [WINDOW];
    logic [STAMP_W-1:0]         win_stamp_reg [WINDOW];
    logic [CNT_W-1:0]           seen_reg;
    logic                       fin_reg;
    logic signed [SAMPLE_W-1:0] old_reg;
    logic signed [SUM_W-1:0]    s_reg;
    logic signed [PW-1:0]       q_reg;
    logic signed [PW-1:0]       prod_reg;
    logic signed [PW-1:0]       lhs_reg;
    logic signed [PW-1:0]       wq_reg;
    logic [CNT_W-1:0]           idx_reg;
    logic [CNT_W-1:0]           stop_reg;

    logic                       accept;
    logic signed [SAMPLE_W-1:0] old_w;
    logic signed [DW-1:0]       diff_w;
    logic signed [DW-1:0]       mul_op;
    logic signed [PW-1:0]       prod_w;
    logic                       kept_w;
    logic [CNT_W-1:0]           start_w;
    logic [CNT_W-1:0]           stop_w;
    logic                       emit_last;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign old_w   = (seen_reg == WIN_CNT) ? win_val_reg[0] : '0;
    assign diff_w  = WIN_D * DW'(win_val_reg[MID]) - DW'(s_reg);

    // the one multiplier only ever squares
    always_comb begin
        case (state_reg)
            ST_IDLE: mul_op = DW'(s_data.sample);
            ST_OLD:  mul_op = DW'(old_reg);
            ST_DIFF: mul_op = diff_w;
            ST_SQ:   mul_op = DW'(s_reg);
            default: mul_op = '0;
        endcase
    end
    assign prod_w = mul_op * mul_op;

    // middle kept when (W*v - S)^2 <= W*Q - S^2
    assign kept_w = (lhs_reg <= (wq_reg - prod_reg));

    always_comb begin
        if (state_reg == ST_CMP) begin
            start_w = kept_w ? MID_CNT : MID_NXT;
            stop_w  = fin_reg ? WIN_CNT : MID_NXT;
        end else if (seen_reg <= MID_CNT) begin
            start_w = seen_reg - CNT_W'(1);
            stop_w  = seen_reg;
        end else if (fin_reg) begin
            start_w = MID_CNT;
            stop_w  = seen_reg;
        end else begin
            start_w = '0;
            stop_w  = '0;
        end
    end

    assign emit_last              = (idx_reg + CNT_W'(1) == stop_reg);
    assign push_valid             = (state_reg == ST_EMIT);
    assign push_data.stamp        = win_stamp_reg[idx_reg[IDX_W-1:0]];
    assign push_data.sample       = win_val_reg[idx_reg[IDX_W-1:0]];
    assign push_data.run_last     = emit_last;
    assign push_data.stream_done  = emit_last && fin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seen_reg  <= '0;
            s_reg     <= '0;
            q_reg     <= '0;
            idx_reg   <= '0;
            stop_reg  <= '0;
            fin_reg   <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (seen_reg == WIN_CNT) begin
                            for (int i = 0; i < WINDOW - 1; i++) begin
                                win_val_reg[i]   <= win_val_reg[i + 1];
                                win_stamp_reg[i] <= win_stamp_reg[i + 1];
                            end
                            win_val_reg[WINDOW-1]   <= s_data.sample;
                            win_stamp_reg[WINDOW-1] <= s_data.stamp;
                        end else begin
                            win_val_reg[seen_reg[IDX_W-1:0]]   <= s_data.sample;
                            win_stamp_reg[seen_reg[IDX_W-1:0]] <= s_data.stamp;
                            seen_reg <= seen_reg + CNT_W'(1);
                        end
                        // running sum tracks the window incrementally
                        s_reg     <= s_reg + SUM_W'(s_data.sample) - SUM_W'(old_w);
                        old_reg   <= old_w;
                        fin_reg   <= s_data.final_sample;
                        prod_reg  <= prod_w;
                        state_reg <= ST_OLD;
                    end
                end
                ST_OLD: begin
                    prod_reg <= prod_w;
                    if (seen_reg == WIN_CNT) begin
                        q_reg     <= q_reg + prod_reg;
                        state_reg <= ST_DIFF;
                    end else begin
                        idx_reg  <= start_w;
                        stop_reg <= stop_w;
                        if (fin_reg) begin
                            seen_reg <= '0;
                            s_reg    <= '0;
                            q_reg    <= '0;
                        end else begin
                            q_reg <= q_reg + prod_reg;
                        end
                        state_reg <= (start_w != stop_w) ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_DIFF: begin
                    q_reg     <= q_reg - prod_reg;
                    prod_reg  <= prod_w;
                    state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    lhs_reg   <= prod_reg;
                    prod_reg  <= prod_w;
                    wq_reg    <= WIN_P * q_reg;
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    idx_reg  <= start_w;
                    stop_reg <= stop_w;
                    if (fin_reg) begin
                        seen_reg <= '0;
                        s_reg    <= '0;
                        q_reg    <= '0;
                    end
                    state_reg <= (start_w != stop_w) ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (push_ready) begin
                        idx_reg <= idx_reg + CNT_W'(1);
                        if (emit_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/wsof_fifo.sv
// short queue of kept samples between the front and the back part
// uses wsof_pkg for the entry type and depth
module wsof_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  wsof_pkg::wsof_emit_t  push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output wsof_pkg::wsof_emit_t  pop_data
);
    import wsof_pkg::*;

    wsof_emit_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + FIFO_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - FIFO_CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/wsof_back.sv
// back part: counts kept samples and drives the registered result channel
// uses wsof_pkg
module wsof_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  wsof_pkg::wsof_emit_t  pop_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output wsof_pkg::wsof_out_t   m_data
);
    import wsof_pkg::*;

    logic              m_valid_reg;
    wsof_out_t         m_data_reg;
    logic [KEPT_W-1:0] kept_reg;
    logic [KEPT_W-1:0] kept_next;
    logic              load;

    assign pop_ready = !m_valid_reg || m_ready;
    assign load      = pop_valid && pop_ready;
    assign kept_next = (kept_reg == KEPT_MAX) ? kept_reg : kept_reg + KEPT_W'(1);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg.out_stamp   <= pop_data.stamp;
            m_data_reg.out_sample  <= pop_data.sample;
            m_data_reg.run_last    <= pop_data.run_last;
            m_data_reg.stream_done <= pop_data.stream_done;
            m_data_reg.kept_total  <= kept_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            kept_reg    <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                // count restarts after the end of a stream
                kept_reg    <= pop_data.stream_done ? '0 : kept_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/window_sigma_outlier_filter_core.sv
// Sliding-window sigma outlier filter. Holds the latest WINDOW samples; the first WINDOW/2
// of a stream pass through, and every full window keeps its middle sample when
// (W*v - S)^2 <= W*Q - S^2, S and Q being the window sum and sum of squares kept as
// running totals. The sample marked final_sample flushes the held samples after the
// middle and ends the stream, with stream_done on its last result. The input side takes
// one sample at a time and steps through ST_IDLE, ST_OLD, ST_DIFF, ST_SQ and ST_CMP once
// the window is full (one squaring multiplier used four times in sequence: new sample,
// dropped sample, difference, sum), or ST_IDLE and ST_OLD while it fills, then pushes each
// result into a 4-entry queue, stalling while the queue is full. The result side is a
// registered valid/ready stage fed from that queue, so results drain while the next
// sample is being worked on. Built from wsof_pkg, wsof_front, wsof_fifo and wsof_back.
`include "window_sigma_outlier_filter_core_macros.svh"

module window_sigma_outlier_filter_core #(
    parameter int WINDOW = wsof_pkg::WINDOW_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wsof_pkg::wsof_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wsof_pkg::wsof_out_t  m_data
);
    import wsof_pkg::*;

    logic       push_valid;
    logic       push_ready;
    wsof_emit_t push_data;
    logic       pop_valid;
    logic       pop_ready;
    wsof_emit_t pop_data;

    wsof_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    wsof_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    wsof_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // front is busy in the cycle after every transfer in
    `WSOF_ASSERT_NEXT(a_busy_after_in, s_valid && s_ready, !s_ready, "front took two samples back to back")
    // the end of a stream is always the last result of its sample
    `WSOF_ASSERT_NOW(a_done_is_last, push_valid && push_data.stream_done, push_data.run_last, "stream_done without run_last")
    // every result counts itself
    `WSOF_ASSERT_NOW(a_kept_nonzero, m_valid, m_data.kept_total != '0, "result with zero kept count")

endmodule

// File: tb/sv/wsof_checker.sv
// result checker for the window sigma outlier filter core: predicts the kept samples of
// every accepted input transfer and compares each output transfer against them
// depends on wsof_pkg
module wsof_checker #(
    parameter int WINDOW = wsof_pkg::WINDOW_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  wsof_pkg::wsof_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  wsof_pkg::wsof_out_t m_data,
    output int                  mismatches,
    output int                  results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import wsof_pkg::*;

    localparam int MID = WINDOW / 2;

    logic signed [SAMPLE_W-1:0] held_val   [WINDOW];
    logic [STAMP_W-1:0]         held_stamp [WINDOW];
    int                         held_n;
    logic [KEPT_W-1:0]          kept_n;

    wsof_out_t step_results [$];
    wsof_out_t kept_expected [$];
    int        fail_count = 0;

    assign mismatches = fail_count;

    function automatic void clear_window();
        int i;
        for (i = 0; i < WINDOW; i++) begin
            held_val[i] = '0;
            held_stamp[i] = '0;
        end
        held_n = 0;
        kept_n = '0;
    endfunction

    // exact integer form of |v - mean| <= sigma for the middle entry
    function automatic bit middle_within_sigma();
        longint sum, sumsq, dev, x;
        int i;
        sum = 0;
        sumsq = 0;
        for (i = 0; i < WINDOW; i++) begin
            x = held_val[i];
            sum += x;
            sumsq += x * x;
        end
        dev = longint'(WINDOW) * longint'(held_val[MID]) - sum;
        return dev * dev <= longint'(WINDOW) * sumsq - sum * sum;
    endfunction

    function automatic void keep_sample(input logic [STAMP_W-1:0] st,
                                        input logic signed [SAMPLE_W-1:0] v);
        wsof_out_t r;
        if (kept_n != KEPT_MAX)
            kept_n++;
        r = '0;
        r.out_stamp = st;
        r.out_sample = v;
        r.kept_total = kept_n;
        step_results.push_back(r);
    endfunction

    function automatic void filter_sample(input wsof_in_t item);
        wsof_out_t tail;
        int i;
        step_results.delete();
        if (held_n < WINDOW) begin
            held_val[held_n] = item.sample;
            held_stamp[held_n] = item.stamp;
            held_n++;
        end else begin
            for (i = 0; i + 1 < WINDOW; i++) begin
                held_val[i] = held_val[i+1];
                held_stamp[i] = held_stamp[i+1];
            end
            held_val[WINDOW-1] = item.sample;
            held_stamp[WINDOW-1] = item.stamp;
        end

        if (held_n >= WINDOW) begin
            if (middle_within_sigma())
                keep_sample(held_stamp[MID], held_val[MID]);
            if (item.final_sample)
                for (i = MID + 1; i < WINDOW; i++)
                    keep_sample(held_stamp[i], held_val[i]);
        end else if (held_n <= MID) begin
            keep_sample(item.stamp, item.sample);
        end else if (item.final_sample) begin
            // short stream: everything past the pass-through part comes out unfiltered
            for (i = MID; i < held_n; i++)
                keep_sample(held_stamp[i], held_val[i]);
        end

        if (step_results.size() > 0) begin
            tail = step_results.pop_back();
            tail.run_last = 1'b1;
            tail.stream_done = item.final_sample;
            step_results.push_back(tail);
        end
        while (step_results.size() > 0)
            kept_expected.push_back(step_results.pop_front());

        if (item.final_sample) begin
            held_n = 0;
            kept_n = '0;
        end
    endfunction

    function automatic void report_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
        fail_count++;
    endfunction

    function automatic void compare_kept(input wsof_out_t want, input wsof_out_t got);
        if (got.out_stamp !== want.out_stamp)
            report_field("out_stamp", want.out_stamp, got.out_stamp);
        if (got.out_sample !== want.out_sample)
            report_field("out_sample", want.out_sample, got.out_sample);
        if (got.run_last !== want.run_last)
            report_field("run_last", want.run_last, got.run_last);
        if (got.stream_done !== want.stream_done)
            report_field("stream_done", want.stream_done, got.stream_done);
        if (got.kept_total !== want.kept_total)
            report_field("kept_total", want.kept_total, got.kept_total);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_window();
            kept_expected.delete();
        end else begin
            // results are registered, so a result never belongs to the input of the same edge
            if (m_valid && m_ready) begin
                if (kept_expected.size() == 0) begin
                    $display("%0t: result expected none actual %h", $time, m_data);
                    fail_count++;
                end else begin
                    compare_kept(kept_expected.pop_front(), m_data);
                end
            end
            if (s_valid && s_ready)
                filter_sample(s_data);
        end
        results_owed <= kept_expected.size();
    end

endmodule

// File: tb/sv/window_sigma_outlier_filter_core_tb.sv
// testbench top for window_sigma_outlier_filter_core: drives directed and random sample
// streams with random idling on both channels and gives the verdict
// depends on wsof_pkg, wsof_checker and the core RTL
module window_sigma_outlier_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsof_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam int PHASE_ITEMS = 128;
    localparam int END_WAIT = 50;

    typedef enum int {
        MODE_CLUSTER,
        MODE_UNIFORM,
        MODE_FLAT,
        MODE_EXTREME
    } value_mode_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    wsof_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    wsof_out_t m_data;

    int mismatches;
    int results_owed;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sent = 0;
    logic [STAMP_W-1:0] next_stamp = '0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    window_sigma_outlier_filter_core #(.WINDOW(WINDOW_DEF)) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    wsof_checker #(.WINDOW(WINDOW_DEF)) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // called at a rising edge; returns at the edge where the transfer happens
    task automatic push_sample(input logic [STAMP_W-1:0] st,
                               input logic signed [SAMPLE_W-1:0] v, input bit fin);
        wsof_in_t item;
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        item.stamp = st;
        item.sample = v;
        item.final_sample = fin;
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // hold off the sender until every predicted result has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    task automatic play_stream(input int len, input value_mode_t mode);
        logic signed [SAMPLE_W-1:0] base, v;
        bit fin;
        int i;
        base = SAMPLE_W'($urandom);
        if ($urandom_range(9) == 0)
            next_stamp = $urandom;
        for (i = 0; i < len; i++) begin
            case (mode)
                MODE_CLUSTER: begin
                    if ($urandom_range(9) == 0)
                        v = SAMPLE_W'($urandom);
                    else
                        v = base + SAMPLE_W'($urandom_range(30)) - SAMPLE_W'(15);
                end
                MODE_UNIFORM: v = SAMPLE_W'($urandom);
                MODE_FLAT: v = base;
                default: begin
                    case ($urandom_range(3))
                        0: v = SAMPLE_MIN;
                        1: v = SAMPLE_MAX;
                        2: v = '0;
                        default: v = -16'sd1;
                    endcase
                end
            endcase
            // now and then a stream is cut short
            fin = (i == len - 1) || ($urandom_range(49) == 0);
            if ($urandom_range(149) == 0)
                drain_results();
            push_sample(next_stamp, v, fin);
            next_stamp = next_stamp + $urandom_range(1000, 1);
            if (fin)
                break;
        end
    endtask

    initial begin
        int phase, phase_start, len, pick;
        value_mode_t mode;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 13;
        recv_idle_pct = 71;

        // single sample stream, all extremes
        push_sample(32'h0000_0000, SAMPLE_MIN, 1'b1);
        // short stream of three: two pass, one flushed
        push_sample(32'hffff_ffff, SAMPLE_MAX, 1'b0);
        push_sample(32'h0000_0001, 16'sd0, 1'b0);
        push_sample(32'h8000_0000, -16'sd1, 1'b1);
        // short stream of four: two flushed at the end
        push_sample(32'h1234_5678, 16'sd100, 1'b0);
        push_sample(32'h1234_5679, -16'sd100, 1'b0);
        push_sample(32'h1234_567a, SAMPLE_MAX, 1'b0);
        push_sample(32'h1234_567b, SAMPLE_MIN, 1'b1);
        // outlier reaches the middle on the final sample: rejected, then flush
        push_sample(32'h0000_0010, 16'sd0, 1'b0);
        push_sample(32'h0000_0011, 16'sd0, 1'b0);
        push_sample(32'h0000_0012, 16'sd0, 1'b0);
        push_sample(32'h0000_0013, 16'sd0, 1'b0);
        push_sample(32'h0000_0014, SAMPLE_MAX, 1'b0);
        push_sample(32'h0000_0015, 16'sd0, 1'b0);
        push_sample(32'h7fff_ffff, 16'sd0, 1'b1);
        // flat window at the negative extreme: kept middle plus full flush
        repeat (4) push_sample(32'hffff_fffe, SAMPLE_MIN, 1'b0);
        push_sample(32'h5555_aaaa, SAMPLE_MIN, 1'b1);
        drain_results();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 71;
                end
                1: begin
                    send_idle_pct = 71;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = sent;
            while (sent - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(9);
                if (pick < 2)
                    len = $urandom_range(4, 1);
                else if (pick < 9)
                    len = $urandom_range(16, 5);
                else
                    len = $urandom_range(40, 17);
                pick = $urandom_range(99);
                if (pick < 55)
                    mode = MODE_CLUSTER;
                else if (pick < 75)
                    mode = MODE_UNIFORM;
                else if (pick < 85)
                    mode = MODE_FLAT;
                else
                    mode = MODE_EXTREME;
                play_stream(len, mode);
            end
            drain_results();
        end

        repeat (END_WAIT) @(posedge aclk);
        if (mismatches == 0 && results_owed == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
